// ===== hdl/rgbd_pkg.sv =====
package rgbd_pkg;

	// item opcodes
	typedef enum logic [1:0] {
		OP_SET   = 2'd0,
		OP_OFF   = 2'd1,
		OP_FLASH = 2'd2,
		OP_TICK  = 2'd3
	} op_t;

	// register map, index = paddr[2]
	localparam logic REG_BRIGHTNESS = 1'b0;
	localparam logic REG_INVERT     = 1'b1;

	localparam logic [7:0]  BRIGHTNESS_RST = 8'd255;
	localparam logic [15:0] ELAPSED_MAX    = 16'hFFFF;

	typedef struct packed {
		logic [7:0] brightness;
		logic       invert;
	} cfg_t;

	typedef struct packed {
		logic [7:0] red_drive;
		logic [7:0] green_drive;
		logic [7:0] blue_drive;
		logic       levels_written;
	} res_t;

endpackage

// ===== hdl/rgb_led_dimmer_flasher.sv =====
// RGB LED dimmer/flasher. Each input transfer carries an opcode in tuser (set color,
// off, start flash, one-millisecond tick) and the color and flash period in tdata; each
// one yields exactly one output transfer with the held red/green/blue PWM duties and a
// flag telling whether the levels were rewritten. Written levels are scaled by
// brightness/255 (truncated) and inverted when the invert register is set; both registers
// sit on the APB port (brightness at 0x0, invert at 0x4) and apply from the next write
// on. The block takes one item per clock when the output is not stalled; an input register
// and a result register lie in its path, with the 8x8 scaling multiply and the flash
// counter compare between them. Flash state and held levels reset to zero.
module rgb_led_dimmer_flasher
	import rgbd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// stream in
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [39:0] s_axis_tdata,  // red_level, green_level, blue_level, flash_period
	input  logic [1:0]  s_axis_tuser,  // opcode
	// stream out
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,  // red_drive, green_drive, blue_drive
	output logic        m_axis_tuser,  // levels_written
	// APB
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	cfg_t        cfg_q;
	logic        valid_s1;
	op_t         opcode_s1;
	logic [23:0] color_s1;
	logic [15:0] period_s1;
	logic        valid_s2;
	res_t        res_s2;
	res_t        res;
	logic        advance;
	logic        wr_en;

	// config registers
	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.brightness <= BRIGHTNESS_RST;
			cfg_q.invert     <= 1'b0;
		end else if (wr_en) begin
			if (paddr[2] == REG_BRIGHTNESS) begin
				cfg_q.brightness <= pwdata[7:0];
			end else begin
				cfg_q.invert <= pwdata[0];
			end
		end
	end

	always_comb begin
		prdata = 32'd0;
		if (paddr[2] == REG_INVERT) begin
			prdata[0] = cfg_q.invert;
		end else begin
			prdata[7:0] = cfg_q.brightness;
		end
	end

	// stage 1 moves on whenever the result register is free or being drained
	assign advance       = valid_s1 && (!valid_s2 || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			opcode_s1 <= op_t'(s_axis_tuser);
			color_s1  <= {s_axis_tdata[7:0], s_axis_tdata[15:8], s_axis_tdata[23:16]};
			period_s1 <= s_axis_tdata[39:24];
		end
	end

	rgbd_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.take         (advance),
		.opcode       (opcode_s1),
		.color        (color_s1),
		.flash_period (period_s1),
		.cfg          (cfg_q),
		.res          (res)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || m_axis_tready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = {res_s2.blue_drive, res_s2.green_drive, res_s2.red_drive};
	assign m_axis_tuser  = res_s2.levels_written;

endmodule

// ===== hdl/rgbd_scale.sv =====
module rgbd_scale
	import rgbd_pkg::*;
(
	input  logic [7:0] level,
	input  cfg_t       cfg,
	output logic [7:0] drive
);

	logic [15:0] prod;
	logic [16:0] sum;
	logic [7:0]  quot;

	// level*brightness/255, exact for 8x8 products: (p + (p>>8) + 1) >> 8
	assign prod = level * cfg.brightness;
	assign sum  = {1'b0, prod} + {9'd0, prod[15:8]} + 17'd1;
	assign quot = sum[15:8];

	// common anode drives the complement
	assign drive = cfg.invert ? ~quot : quot;

endmodule

// ===== hdl/rgbd_ctrl.sv =====
module rgbd_ctrl
	import rgbd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        take,
	input  op_t         opcode,
	input  logic [23:0] color,
	input  logic [15:0] flash_period,
	input  cfg_t        cfg,
	output res_t        res
);

	logic        flash_active_q;
	logic        flash_lit_q;
	logic [23:0] flash_color_q;
	logic [14:0] half_period_q;
	logic [15:0] elapsed_q;
	logic [23:0] drive_q;

	logic        flash_active_d;
	logic        flash_lit_d;
	logic [23:0] flash_color_d;
	logic [14:0] half_period_d;
	logic [15:0] elapsed_d;
	logic [15:0] elapsed_inc;
	logic        wrote;
	logic [23:0] src;
	logic [23:0] scaled;

	assign elapsed_inc = (elapsed_q < ELAPSED_MAX) ? elapsed_q + 16'd1 : elapsed_q;

	// next state and the color to be written
	always_comb begin
		flash_active_d = flash_active_q;
		flash_lit_d    = flash_lit_q;
		flash_color_d  = flash_color_q;
		half_period_d  = half_period_q;
		elapsed_d      = elapsed_q;
		wrote          = 1'b0;
		src            = 24'd0;
		unique case (opcode)
			OP_SET: begin
				flash_active_d = 1'b0;
				src            = color;
				wrote          = 1'b1;
			end
			OP_OFF: begin
				flash_active_d = 1'b0;
				wrote          = 1'b1;
			end
			OP_FLASH: begin
				flash_color_d  = color;
				half_period_d  = flash_period[15:1];
				flash_active_d = 1'b1;
				elapsed_d      = 16'd0;
				flash_lit_d    = 1'b1;
				src            = color;
				wrote          = 1'b1;
			end
			OP_TICK: begin
				if (flash_active_q) begin
					elapsed_d = elapsed_inc;
					if (elapsed_inc >= {1'b0, half_period_q}) begin
						flash_lit_d = ~flash_lit_q;
						elapsed_d   = 16'd0;
						src         = flash_lit_q ? 24'd0 : flash_color_q;
						wrote       = 1'b1;
					end
				end
			end
			default: ;
		endcase
	end

	// per-channel scaling
	rgbd_scale u_scale_r (.level(src[23:16]), .cfg(cfg), .drive(scaled[23:16]));
	rgbd_scale u_scale_g (.level(src[15:8]),  .cfg(cfg), .drive(scaled[15:8]));
	rgbd_scale u_scale_b (.level(src[7:0]),   .cfg(cfg), .drive(scaled[7:0]));

	// state update on each item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flash_active_q <= 1'b0;
			flash_lit_q    <= 1'b0;
			flash_color_q  <= 24'd0;
			half_period_q  <= 15'd0;
			elapsed_q      <= 16'd0;
			drive_q        <= 24'd0;
		end else if (take) begin
			flash_active_q <= flash_active_d;
			flash_lit_q    <= flash_lit_d;
			flash_color_q  <= flash_color_d;
			half_period_q  <= half_period_d;
			elapsed_q      <= elapsed_d;
			if (wrote) begin
				drive_q <= scaled;
			end
		end
	end

	assign res.red_drive      = wrote ? scaled[23:16] : drive_q[23:16];
	assign res.green_drive    = wrote ? scaled[15:8]  : drive_q[15:8];
	assign res.blue_drive     = wrote ? scaled[7:0]   : drive_q[7:0];
	assign res.levels_written = wrote;

endmodule

// ===== hdl/rgbd_checker.sv =====
module rgbd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [23:0] m_axis_tdata,
	input logic        m_axis_tuser
);

	logic m_xfer;
	assign m_xfer = m_axis_tvalid && m_axis_tready;

	// stalled output holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("output changed while stalled");

	// a result that did not rewrite levels repeats the previous held levels
	a_levels_held: assert property (@(posedge clk) disable iff (!arst_n)
		m_xfer && !m_axis_tuser && $past(m_xfer) |-> m_axis_tdata == $past(m_axis_tdata))
		else $error("held levels changed without a write");

	// an empty output side never blocks the input
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready)
		else $error("input stalled with empty output");

	// nothing is presented once reset has been seen at an edge
	a_reset_quiet: assert property (@(posedge clk)
		!arst_n && $past(!arst_n) |-> !m_axis_tvalid)
		else $error("output valid during reset");

endmodule

bind rgb_led_dimmer_flasher rgbd_checker u_rgbd_checker (.*);
